// File: hw/rtl/mexp_pkg.sv
package mexp_pkg;

    // Fixed field width of the operand and result channels
    localparam int DATA_W = 64;

    typedef struct packed {
        logic [DATA_W-1:0] base_value;
        logic [DATA_W-1:0] exponent_value;
        logic [DATA_W-1:0] modulus_value;
    } mexp_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] power_result;
        logic              zero_modulus_error;
    } mexp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_BIT,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } mexp_state_t;

    // Operand selection for the shared modular multiplier
    typedef enum logic [1:0] {
        MSEL_REDUCE,
        MSEL_ACC,
        MSEL_SQUARE
    } mexp_msel_t;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        mexp_msel_t mul_sel;
        logic       mul_step;
        logic       wb_acc;
        logic       wb_pw;
        logic       exp_shift;
        logic       out_load;
    } mexp_cmd_t;

    typedef struct packed {
        logic mod_trivial;
        logic exp_bit;
        logic exp_zero;
        logic mul_last;
        logic out_free;
    } mexp_status_t;

endpackage

// File: hw/rtl/mexp_controller.sv
module mexp_controller (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  mexp_pkg::mexp_status_t status,
    output mexp_pkg::mexp_cmd_t    cmd
);
    import mexp_pkg::*;

    mexp_state_t state_reg;
    mexp_state_t state_next;

    // Hold or advance the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.mod_trivial ? ST_DONE : ST_REDUCE;
            end
            ST_REDUCE: begin
                if (status.mul_last) begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (status.exp_zero) begin
                    state_next = ST_DONE;
                end else if (status.exp_bit) begin
                    state_next = ST_MULT;
                end else begin
                    state_next = ST_SQUARE;
                end
            end
            ST_MULT: begin
                if (status.mul_last) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (status.mul_last) begin
                    state_next = ST_BIT;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CHECK: begin
                cmd.mul_start = !status.mod_trivial;
                cmd.mul_sel   = MSEL_REDUCE;
            end
            ST_REDUCE: begin
                cmd.mul_step = 1'b1;
                cmd.wb_pw    = status.mul_last;
            end
            ST_BIT: begin
                cmd.mul_start = !status.exp_zero;
                cmd.mul_sel   = status.exp_bit ? MSEL_ACC : MSEL_SQUARE;
            end
            ST_MULT: begin
                cmd.mul_step  = 1'b1;
                cmd.wb_acc    = status.mul_last;
                cmd.mul_start = status.mul_last;
                cmd.mul_sel   = MSEL_SQUARE;
            end
            ST_SQUARE: begin
                cmd.mul_step  = 1'b1;
                cmd.wb_pw     = status.mul_last;
                cmd.exp_shift = status.mul_last;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/mexp_datapath.sv
module mexp_datapath #(
    parameter int WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mexp_pkg::mexp_in_t     s_payload,
    input  mexp_pkg::mexp_cmd_t    cmd,
    output mexp_pkg::mexp_status_t status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mexp_pkg::mexp_out_t    m_payload
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam int EXT_W = WIDTH + 2;

    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] pw_reg;
    logic [WIDTH-1:0] mul_a_reg;
    logic [WIDTH-1:0] mul_b_reg;
    logic [WIDTH-1:0] prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    mexp_out_t        out_reg;
    logic             out_valid_reg;

    logic [EXT_W-1:0] sum_ext;
    logic [EXT_W-1:0] mod1_ext;
    logic [EXT_W-1:0] mod2_ext;
    logic [EXT_W-1:0] diff1_ext;
    logic [EXT_W-1:0] diff2_ext;
    logic [WIDTH-1:0] step_res;
    logic [WIDTH-1:0] start_a;
    logic [WIDTH-1:0] start_b;
    logic             mod_trivial;

    // One double-and-add step: 2*prod + bit*a stays below 3*m
    always_comb begin
        sum_ext   = {1'b0, prod_reg, 1'b0}
                  + (mul_b_reg[WIDTH-1] ? {2'b00, mul_a_reg} : '0);
        mod1_ext  = {2'b00, mod_reg};
        mod2_ext  = {1'b0, mod_reg, 1'b0};
        diff1_ext = sum_ext - mod1_ext;
        diff2_ext = sum_ext - mod2_ext;
        if (sum_ext >= mod2_ext) begin
            step_res = diff2_ext[WIDTH-1:0];
        end else if (sum_ext >= mod1_ext) begin
            step_res = diff1_ext[WIDTH-1:0];
        end else begin
            step_res = sum_ext[WIDTH-1:0];
        end
    end

    // Multiplier operands; reduction of the base is 1 * base mod m
    always_comb begin
        case (cmd.mul_sel)
            MSEL_REDUCE: begin
                start_a = WIDTH'(1);
                start_b = base_reg;
            end
            MSEL_ACC: begin
                start_a = pw_reg;
                start_b = acc_reg;
            end
            MSEL_SQUARE: begin
                start_a = pw_reg;
                start_b = pw_reg;
            end
            default: begin
                start_a = pw_reg;
                start_b = pw_reg;
            end
        endcase
    end

    assign mod_trivial = (mod_reg[WIDTH-1:1] == '0);

    // Operand capture, exponent scan and accumulator
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= s_payload.base_value[WIDTH-1:0];
            exp_reg  <= s_payload.exponent_value[WIDTH-1:0];
            mod_reg  <= s_payload.modulus_value[WIDTH-1:0];
            acc_reg  <= WIDTH'(1);
        end else begin
            if (cmd.exp_shift) begin
                exp_reg <= exp_reg >> 1;
            end
            if (cmd.wb_acc) begin
                acc_reg <= step_res;
            end
        end
        if (cmd.wb_pw) begin
            pw_reg <= step_res;
        end
    end

    // Shared bit-serial modular multiplier
    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            mul_a_reg <= start_a;
            mul_b_reg <= start_b;
            prod_reg  <= '0;
            cnt_reg   <= CNT_W'(WIDTH - 1);
        end else if (cmd.mul_step) begin
            mul_b_reg <= mul_b_reg << 1;
            prod_reg  <= step_res;
            cnt_reg   <= cnt_reg - CNT_W'(1);
        end
    end

    // Result register: parts the sequencer from the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.power_result       <= DATA_W'(mod_trivial ? '0 : acc_reg);
            out_reg.zero_modulus_error <= (mod_reg == '0);
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign status.mod_trivial = mod_trivial;
    assign status.exp_bit     = exp_reg[0];
    assign status.exp_zero    = (exp_reg == '0);
    assign status.mul_last    = (cnt_reg == '0);
    assign status.out_free    = !out_valid_reg || m_ready;

    // A step keeps the partial product reduced
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mul_step && !cmd.mul_start) |=> (prod_reg < mod_reg))
        else $error("partial product not reduced below modulus");

    // The base power written back is reduced
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb_pw |=> (pw_reg < mod_reg))
        else $error("base power not reduced below modulus");

    // A result is never loaded over one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while pending");

    // A fresh request starts the accumulator at one
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (acc_reg == WIDTH'(1)))
        else $error("accumulator not initialized");

endmodule

// File: hw/rtl/modular_exponentiation_unit.sv
// A request is worked as a reduction of the base mod m, then, for each exponent bit from
// bit 0 up to the highest set bit, a multiply into the accumulator if the bit is set and a
// square of the base power. A modulus of zero or one skips the multiplier. One request is
// worked at a time on one bit-serial modular multiplier (one bit per cycle); the result
// register lets the next request be taken while a result waits. Reset (aresetn,
// synchronous, active low) idles the sequencer and drops any result.
module modular_exponentiation_unit #(
    parameter int WIDTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mexp_pkg::mexp_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output mexp_pkg::mexp_out_t m_payload
);
    import mexp_pkg::*;

    mexp_cmd_t    cmd;
    mexp_status_t status;

    mexp_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
